>>> hdl/bfp9_pkg.sv
package bfp9_pkg;

  localparam int unsigned PrbBytes      = 28;
  localparam int unsigned SamplesPerPrb = 24;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MantW   = 9;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ExpW    = 4;
  localparam int unsigned CountW  = 9;
  localparam int unsigned IdxW    = 5;

  localparam logic [CountW-1:0] PrbCountReset = CountW'(273);

  localparam logic [MantW-1:0]   MantMask = 9'h1FF;
  localparam logic [MantW-1:0]   MantSign = 9'h100;
  localparam logic [SampleW-1:0] MantExt  = 16'hFE00;

  // one decoded result word plus its valid flag
  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] sample;
    logic               is_quadrature;
    logic               last_in_prb;
    logic               last_in_packet;
    logic               too_short;
  } bfp9_res_t;

  // sign-extend a 9-bit mantissa and scale it by the block exponent, wrapping to 16 bits
  function automatic logic [SampleW-1:0] expand(input logic [MantW-1:0] raw,
                                               input logic [ExpW-1:0]  expo);
    logic [SampleW-1:0] ext;
    ext = {{(SampleW-MantW){1'b0}}, raw & MantMask};
    if ((raw & MantSign) != '0) begin
      ext = ext | MantExt;
    end
    return ext << expo;
  endfunction

endpackage

>>> hdl/bfp9_unpack.sv
module bfp9_unpack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [bfp9_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         end_of_buffer_i,
  input  logic [bfp9_pkg::CountW-1:0]  prb_count_i,
  output bfp9_pkg::bfp9_res_t          res_o
);

  logic [bfp9_pkg::ExpW-1:0]    exp_q, exp_d;
  logic [bfp9_pkg::SampleW-1:0] acc_q, acc_d;
  logic [bfp9_pkg::IdxW-1:0]    bits_q, bits_d;
  logic [bfp9_pkg::IdxW-1:0]    byte_idx_q, byte_idx_d;
  logic [bfp9_pkg::IdxW-1:0]    smp_idx_q, smp_idx_d;
  logic [bfp9_pkg::CountW-1:0]  prbs_q, prbs_d;

  logic [bfp9_pkg::IdxW-1:0]    bits_sum;
  logic [bfp9_pkg::IdxW-1:0]    bits_left;
  logic [bfp9_pkg::IdxW-1:0]    byte_next;
  logic [bfp9_pkg::CountW-1:0]  prbs_inc;
  logic [bfp9_pkg::SampleW-1:0] acc_shift;
  logic [bfp9_pkg::MantW-1:0]   raw;
  logic                         all_done;

  always_comb begin
    exp_d      = exp_q;
    acc_d      = acc_q;
    bits_d     = bits_q;
    byte_idx_d = byte_idx_q;
    smp_idx_d  = smp_idx_q;
    prbs_d     = prbs_q;
    res_o      = '0;
    all_done   = 1'b0;
    bits_sum   = bits_q + bfp9_pkg::IdxW'(8);
    bits_left  = bits_sum - bfp9_pkg::IdxW'(9);
    byte_next  = byte_idx_q + bfp9_pkg::IdxW'(1);
    prbs_inc   = prbs_q + bfp9_pkg::CountW'(1);
    acc_shift  = {acc_q[7:0], data_byte_i} >> bits_left[2:0];
    raw        = acc_shift[bfp9_pkg::MantW-1:0];

    if (accept_i) begin
      if (prbs_q >= prb_count_i) begin
        // trailing bytes: only the end mark matters
        if (end_of_buffer_i) begin
          acc_d      = '0;
          bits_d     = '0;
          byte_idx_d = '0;
          smp_idx_d  = '0;
          prbs_d     = '0;
        end
      end else begin
        if (byte_idx_q == '0) begin
          exp_d     = data_byte_i[bfp9_pkg::ExpW-1:0];
          acc_d     = '0;
          bits_d    = '0;
          smp_idx_d = '0;
        end else begin
          acc_d = {acc_q[7:0], data_byte_i};
          if (bits_sum >= bfp9_pkg::IdxW'(9) &&
              smp_idx_q < bfp9_pkg::IdxW'(bfp9_pkg::SamplesPerPrb)) begin
            bits_d               = bits_left;
            res_o.valid          = 1'b1;
            res_o.sample         = bfp9_pkg::expand(raw, exp_q);
            res_o.is_quadrature  = smp_idx_q[0];
            res_o.last_in_prb    =
              (smp_idx_q == bfp9_pkg::IdxW'(bfp9_pkg::SamplesPerPrb - 1));
            res_o.last_in_packet = res_o.last_in_prb && (prbs_inc == prb_count_i);
            smp_idx_d            = smp_idx_q + bfp9_pkg::IdxW'(1);
          end else begin
            bits_d = bits_sum;
          end
        end

        if (byte_next >= bfp9_pkg::IdxW'(bfp9_pkg::PrbBytes)) begin
          byte_idx_d = '0;
          smp_idx_d  = '0;
          bits_d     = '0;
          acc_d      = '0;
          prbs_d     = prbs_inc;
          all_done   = (prbs_inc >= prb_count_i);
        end else begin
          byte_idx_d = byte_next;
        end

        if (end_of_buffer_i) begin
          acc_d      = '0;
          bits_d     = '0;
          byte_idx_d = '0;
          smp_idx_d  = '0;
          prbs_d     = '0;
          if (!all_done) begin
            // early end: the word carries only the error flag
            res_o           = '0;
            res_o.valid     = 1'b1;
            res_o.too_short = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q      <= '0;
      acc_q      <= '0;
      bits_q     <= '0;
      byte_idx_q <= '0;
      smp_idx_q  <= '0;
      prbs_q     <= '0;
    end else begin
      exp_q      <= exp_d;
      acc_q      <= acc_d;
      bits_q     <= bits_d;
      byte_idx_q <= byte_idx_d;
      smp_idx_q  <= smp_idx_d;
      prbs_q     <= prbs_d;
    end
  end

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= bfp9_pkg::IdxW'(8))
    else $error("bit reservoir holds more than one byte");

  a_byte_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q < bfp9_pkg::IdxW'(bfp9_pkg::PrbBytes))
    else $error("byte index past end of PRB");

  a_smp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_idx_q <= bfp9_pkg::IdxW'(bfp9_pkg::SamplesPerPrb))
    else $error("sample index past end of PRB");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.too_short |-> (res_o.sample == '0 && !res_o.last_in_prb &&
                         !res_o.last_in_packet && !res_o.is_quadrature))
    else $error("error word carries sample data");

  a_eob_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_buffer_i) |=> (byte_idx_q == '0 && prbs_q == '0 && bits_q == '0))
    else $error("counters not cleared after end mark");

endmodule

>>> hdl/bfp9_iq_decompressor.sv
// BFP 9-bit IQ decompressor.
// Input stream: one compressed byte per word on s_axis; tlast marks the last
// byte of a buffer. Each PRB is 28 bytes: an exponent byte (low nibble used)
// then 24 packed 9-bit mantissas, MSB first, I and Q alternating.
// Output stream: one 16-bit sample per word on m_axis; tlast marks the last
// sample of the last PRB, tuser carries I/Q, last-of-PRB and the too-short flag.
// An end mark before prb_count PRBs are complete yields one too-short word
// with a zero sample. Bytes after prb_count PRBs yield nothing.
// Throughput: one byte per cycle while the receiver keeps up. Each byte goes
// through a single pass of unpack/scale logic into the output register, so a
// result word is valid the cycle after its byte is taken.
// A stalled receiver holds the output register; the input is still taken
// whenever the output register is empty or being drained in that cycle.
// Reset: prb_count returns to 273, all counters clear, output empty. The user must
// write prb_count via cfg_wr_en_i / cfg_wdata_i only while idle; not enforced.
module bfp9_iq_decompressor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bfp9_pkg::ByteW-1:0]         s_axis_tdata_i,  // [7:0] data_byte
  input  logic                               s_axis_tlast_i,  // end_of_buffer
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [bfp9_pkg::SampleW-1:0]       m_axis_tdata_o,  // [15:0] sample
  output logic                               m_axis_tlast_o,  // last_in_packet
  output logic [2:0]                         m_axis_tuser_o,  // [0] is_quadrature,
                                                              // [1] last_in_prb,
                                                              // [2] too_short
  input  logic                               cfg_wr_en_i,
  input  logic [bfp9_pkg::CountW-1:0]        cfg_wdata_i
);

  logic [bfp9_pkg::CountW-1:0] prb_count_q;
  logic                        out_valid_q, out_valid_d;
  logic                        in_accept;
  bfp9_pkg::bfp9_res_t         res;
  bfp9_pkg::bfp9_res_t         out_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  bfp9_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .data_byte_i     (s_axis_tdata_i),
    .end_of_buffer_i (s_axis_tlast_i),
    .prb_count_i     (prb_count_q),
    .res_o           (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prb_count_q <= bfp9_pkg::PrbCountReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        prb_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.sample;
  assign m_axis_tlast_o  = out_q.last_in_packet;
  assign m_axis_tuser_o  = {out_q.too_short, out_q.last_in_prb, out_q.is_quadrature};

endmodule

>>> dv/tb_bfp9_iq_decompressor.sv
module tb_bfp9_iq_decompressor;

  localparam int CycleLimit = 400_000;

  typedef struct packed {
    logic [bfp9_pkg::SampleW-1:0] sample;
    logic                         quad;
    logic                         lprb;
    logic                         lpkt;
    logic                         too_short;
  } iq_word_t;

  // where the expectation for a byte comes from
  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_RES,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic [bfp9_pkg::ByteW-1:0]  data;
    bit                          eob;
    bit                          rnd;
    int                          reps;
    logic [bfp9_pkg::CountW-1:0] prbs;
    iq_word_t                    word;
  } stim_row_t;

  localparam iq_word_t NoWord    = '0;
  localparam iq_word_t ShortWord = '{16'h0000, 1'b0, 1'b0, 1'b0, 1'b1};

  logic                          clk_i = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic [bfp9_pkg::ByteW-1:0]    s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tready = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [bfp9_pkg::CountW-1:0]   cfg_wdata = '0;
  wire                           s_axis_tready_o;
  wire                           m_axis_tvalid_o;
  wire [bfp9_pkg::SampleW-1:0]   m_axis_tdata_o;
  wire                           m_axis_tlast_o;
  wire [2:0]                     m_axis_tuser_o;

  // travels alongside the byte so the monitor sees it at the accepting edge
  row_kind_e          word_src = ROW_PRED;
  iq_word_t           typed_word = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int cycles = 0;
  int mismatches = 0;

  // predictor state
  logic [bfp9_pkg::CountW-1:0] prb_count_q = bfp9_pkg::PrbCountReset;
  logic [3:0]                  expo_q = '0;
  logic [15:0]                 acc_q = '0;
  logic [4:0]                  nbits_q = '0;
  logic [4:0]                  byte_idx_q = '0;
  logic [4:0]                  smp_idx_q = '0;
  logic [bfp9_pkg::CountW-1:0] prbs_done_q = '0;
  iq_word_t                    pending_iq[$];

  stim_row_t dir_tab [25] = '{
    '{ROW_NONE, 8'hF0, 1'b0, 1'b0, 1,  9'd0,   NoWord},  // exponent 0, reserved nibble set
    '{ROW_NONE, 8'h7F, 1'b0, 1'b0, 1,  9'd0,   NoWord},
    '{ROW_RES,  8'hC0, 1'b0, 1'b0, 1,  9'd0,   '{16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_RES,  8'h00, 1'b0, 1'b0, 1,  9'd0,   '{16'hFF00, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{ROW_RES,  8'h55, 1'b1, 1'b0, 1,  9'd0,   ShortWord},
    '{ROW_NONE, 8'h0F, 1'b0, 1'b0, 1,  9'd0,   NoWord},  // exponent 15
    '{ROW_NONE, 8'h80, 1'b0, 1'b0, 1,  9'd0,   NoWord},
    '{ROW_RES,  8'h80, 1'b0, 1'b0, 1,  9'd0,   '{16'h8000, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_RES,  8'hFF, 1'b1, 1'b0, 1,  9'd0,   ShortWord},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 0,  9'd1,   NoWord},
    '{ROW_NONE, 8'h03, 1'b0, 1'b0, 1,  9'd0,   NoWord},
    '{ROW_PRED, 8'h00, 1'b0, 1'b1, 26, 9'd0,   NoWord},
    '{ROW_PRED, 8'hA5, 1'b0, 1'b0, 1,  9'd0,   NoWord},  // closes the only PRB
    '{ROW_NONE, 8'h12, 1'b0, 1'b0, 1,  9'd0,   NoWord},  // trailing
    '{ROW_NONE, 8'h34, 1'b1, 1'b0, 1,  9'd0,   NoWord},  // trailing end mark, no error
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 0,  9'd0,   NoWord},
    '{ROW_NONE, 8'h00, 1'b0, 1'b1, 3,  9'd0,   NoWord},
    '{ROW_NONE, 8'hC3, 1'b1, 1'b0, 1,  9'd0,   NoWord},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 0,  9'd511, NoWord},
    '{ROW_RES,  8'h5A, 1'b1, 1'b0, 1,  9'd0,   ShortWord},  // end mark on exponent byte
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 0,  9'd2,   NoWord},
    '{ROW_PRED, 8'h00, 1'b0, 1'b1, 27, 9'd0,   NoWord},
    '{ROW_RES,  8'hE7, 1'b1, 1'b0, 1,  9'd0,   ShortWord},  // ends on first PRB of two
    '{ROW_PRED, 8'h00, 1'b0, 1'b1, 55, 9'd0,   NoWord},
    '{ROW_PRED, 8'h6C, 1'b1, 1'b0, 1,  9'd0,   NoWord}
  };

  bfp9_iq_decompressor DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void restart_buffer();
    acc_q       = '0;
    nbits_q     = '0;
    byte_idx_q  = '0;
    smp_idx_q   = '0;
    prbs_done_q = '0;
  endfunction

  // unpack one byte of the stream; returns 1 if it yields an output word (a sample or a too-short word)
  function automatic bit decode_byte(input logic [bfp9_pkg::ByteW-1:0] b, input bit eob,
                                     output iq_word_t w);
    logic [bfp9_pkg::MantW-1:0]   raw;
    logic [bfp9_pkg::SampleW-1:0] ext;
    bit                           have;
    bit                           done_all;
    have     = 1'b0;
    done_all = 1'b0;
    w        = '0;
    if (prbs_done_q >= prb_count_q) begin
      if (eob) restart_buffer();
      return 1'b0;
    end
    if (byte_idx_q == 0) begin
      expo_q    = b[3:0];
      acc_q     = '0;
      nbits_q   = '0;
      smp_idx_q = '0;
    end else begin
      acc_q   = {acc_q[7:0], b};
      nbits_q = nbits_q + 5'd8;
      if (nbits_q >= 9 && smp_idx_q < bfp9_pkg::SamplesPerPrb) begin
        raw      = bfp9_pkg::MantW'(acc_q >> (nbits_q - 5'd9));
        ext      = {{(bfp9_pkg::SampleW-bfp9_pkg::MantW){raw[bfp9_pkg::MantW-1]}}, raw};
        nbits_q  = nbits_q - 5'd9;
        w.sample = ext << expo_q;
        w.quad   = smp_idx_q[0];
        w.lprb   = (smp_idx_q == bfp9_pkg::SamplesPerPrb - 1);
        w.lpkt   = w.lprb && (prbs_done_q + 1 == prb_count_q);
        smp_idx_q = smp_idx_q + 5'd1;
        have     = 1'b1;
      end
    end
    byte_idx_q = byte_idx_q + 5'd1;
    if (byte_idx_q >= bfp9_pkg::PrbBytes) begin
      byte_idx_q  = '0;
      smp_idx_q   = '0;
      nbits_q     = '0;
      acc_q       = '0;
      prbs_done_q = prbs_done_q + 1'b1;
      done_all    = (prbs_done_q >= prb_count_q);
    end
    if (eob) begin
      restart_buffer();
      if (!done_all) begin
        w = ShortWord;
        return 1'b1;
      end
    end
    return have;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [bfp9_pkg::SampleW-1:0] want,
                                      input logic [bfp9_pkg::SampleW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // receiver side: random stalls, plus a forced hold-off when asked
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // input and output monitor, prediction and scoreboard
  always @(posedge clk_i) begin
    iq_word_t pred_w;
    iq_word_t want_w;
    bit       have;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) prb_count_q = cfg_wdata;
      if (s_tvalid && s_axis_tready_o) begin
        have = decode_byte(s_tdata, s_tlast, pred_w);
        case (word_src)
          ROW_RES:  pending_iq.push_back(typed_word);
          ROW_NONE: ;
          default:  if (have) pending_iq.push_back(pred_w);
        endcase
      end
      if (m_axis_tvalid_o && m_tready) begin
        if (pending_iq.size() == 0) begin
          $error("unexpected word: sample %h tuser %b tlast %b",
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          want_w = pending_iq.pop_front();
          check_field("sample", want_w.sample, m_axis_tdata_o);
          check_field("is_quadrature", bfp9_pkg::SampleW'(want_w.quad),
                      bfp9_pkg::SampleW'(m_axis_tuser_o[0]));
          check_field("last_in_prb", bfp9_pkg::SampleW'(want_w.lprb),
                      bfp9_pkg::SampleW'(m_axis_tuser_o[1]));
          check_field("last_in_packet", bfp9_pkg::SampleW'(want_w.lpkt),
                      bfp9_pkg::SampleW'(m_axis_tlast_o));
          check_field("too_short", bfp9_pkg::SampleW'(want_w.too_short),
                      bfp9_pkg::SampleW'(m_axis_tuser_o[2]));
        end
      end
    end
  end

  task automatic offer_byte(input logic [bfp9_pkg::ByteW-1:0] b, input bit eob,
                            input row_kind_e k, input iq_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    s_tlast    <= eob;
    word_src   <= k;
    typed_word <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // stop offering and wait for every expected word, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_iq.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // waits after the write so the new count is seen before the next buffer
  task automatic write_prb_count(input logic [bfp9_pkg::CountW-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [bfp9_pkg::CountW-1:0] pick_prb_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return bfp9_pkg::CountW'($urandom_range(1, 4));
    if (r < 85) return bfp9_pkg::CountW'($urandom_range(5, 12));
    if (r < 91) return '0;
    if (r < 96) return '1;
    return bfp9_pkg::PrbCountReset;
  endfunction

  // one buffer: mostly well formed, some with trailing bytes, some cut short
  task automatic send_buffer(input bit whole, output int counted);
    int full;
    int len;
    int r;
    full = int'(prb_count_q) * bfp9_pkg::PrbBytes;
    r    = $urandom_range(99);
    if (whole) len = full;
    else if (prb_count_q == 0 || prb_count_q > 12) len = $urandom_range(1, 60);
    else if (r < 70) len = full;
    else if (r < 82) len = full + $urandom_range(1, 6);
    else len = $urandom_range(1, full - 1);
    for (int k = 0; k < len; k++)
      offer_byte(8'($urandom), k == len - 1, ROW_PRED, NoWord);
    counted = (len > full) ? full : len;
  endtask

  initial begin
    int sent;
    int got_n;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_prb_count(dir_tab[i].prbs);
      end else begin
        for (int n = 0; n < dir_tab[i].reps; n++)
          offer_byte(dir_tab[i].rnd ? 8'($urandom) : dir_tab[i].data,
                     dir_tab[i].eob && (n == dir_tab[i].reps - 1),
                     dir_tab[i].kind, dir_tab[i].word);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 71 : 0;
      rx_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 25 : 0;
      write_prb_count(pick_prb_count());
      sent = 0;
      // long receiver hold-off: input must back up and stall
      if (ph == 2) begin
        write_prb_count(bfp9_pkg::CountW'(4));
        rx_hold = 400;
        send_buffer(1'b1, sent);
      end
      while (sent < 200) begin
        if ($urandom_range(5) == 0) write_prb_count(pick_prb_count());
        send_buffer(1'b0, got_n);
        sent += got_n;
        if ($urandom_range(7) == 0) drain();
      end
    end

    // one well-formed buffer to finish
    write_prb_count(bfp9_pkg::CountW'(3));
    send_buffer(1'b1, got_n);
    drain();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
